// File: src/akf_pkg.sv
// Shared types, constants and a saturation helper for the angle/gyro Kalman filter.
package akf_pkg;

	localparam int DATA_W  = 32;
	localparam int CFG_W   = 31;
	localparam int CIDX_W  = 8;
	localparam int FRAC_W  = 24;

	localparam logic [CFG_W-1:0] Q_ANGLE_RST = 31'd2684355;
	localparam logic [CFG_W-1:0] Q_GYRO_RST  = 31'd16777216;
	localparam logic [CFG_W-1:0] R_MEAS_RST  = 31'd83886;
	localparam logic [CFG_W-1:0] DT_RST      = 31'd100663;
	localparam logic signed [DATA_W-1:0] ONE_Q24 = 32'sd16777216;

	typedef enum logic [CIDX_W-1:0] {
		REG_Q_ANGLE = 8'd0,
		REG_Q_GYRO  = 8'd1,
		REG_R_MEAS  = 8'd2,
		REG_DT      = 8'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_WB, ST_DIV0, ST_DIV0W, ST_DIV1, ST_DIV1W, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_ANG_P, OP_AA_P, OP_AB_P, OP_BB_P,
		OP_AA_C, OP_AB_C, OP_BA_C, OP_BB_C, OP_ANG_C, OP_BIAS_C
	} op_t;

	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] num;
		logic signed [DATA_W:0]   den;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic signed [DATA_W-1:0] quo;
	} div_rsp_t;

	function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] x);
		logic signed [DATA_W+1:0] hi;
		logic signed [DATA_W+1:0] lo;
		hi = 34'sh0_7FFF_FFFF;
		lo = -34'sh0_8000_0000;
		if (x > hi)
			return 32'sh7FFF_FFFF;
		else if (x < lo)
			return 32'sh8000_0000;
		else
			return x[DATA_W-1:0];
	endfunction

endpackage

// File: src/akf_if.sv
// Stream interfaces for the sample and result channels.
interface akf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] accel_angle;
	logic signed [31:0] gyro_rate;
	modport source(output valid, accel_angle, gyro_rate, input ready);
	modport sink(input valid, accel_angle, gyro_rate, output ready);
endinterface

interface akf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] angle_estimate;
	logic signed [31:0] rate_estimate;
	logic signed [31:0] bias_estimate;
	modport source(output valid, angle_estimate, rate_estimate, bias_estimate, input ready);
	modport sink(input valid, angle_estimate, rate_estimate, bias_estimate, output ready);
endinterface

// File: src/akf_mul.sv
// Shared Q8.24 multiplier: registered product, round half up, saturate.
module akf_mul (
	input  logic                             clk,
	input  logic signed [akf_pkg::DATA_W-1:0] a,
	input  logic signed [akf_pkg::DATA_W-1:0] b,
	output logic signed [akf_pkg::DATA_W-1:0] p
);
	import akf_pkg::*;

	logic signed [2*DATA_W-1:0] prod_s1;
	logic signed [2*DATA_W:0]   rnd;
	logic signed [2*DATA_W-FRAC_W:0] shr;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_comb begin
		rnd = {prod_s1[2*DATA_W-1], prod_s1} + (65'sd1 <<< (FRAC_W-1));
		shr = rnd[2*DATA_W:FRAC_W];
		if (shr > $signed({{(2*DATA_W-FRAC_W-DATA_W+2){1'b0}}, {(DATA_W-1){1'b1}}}))
			p = 32'sh7FFF_FFFF;
		else if (shr < -$signed({{(2*DATA_W-FRAC_W-DATA_W+1){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}}))
			p = 32'sh8000_0000;
		else
			p = shr[DATA_W-1:0];
	end

endmodule

// File: src/akf_div.sv
// Radix-2 restoring divider for the gains: num * 2^24 / den, truncated, saturated.
module akf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  akf_pkg::div_req_t  req,
	output akf_pkg::div_rsp_t  rsp
);
	import akf_pkg::*;

	localparam int QW = DATA_W + FRAC_W;

	logic            busy_q;
	logic            done_q;
	logic            neg_q;
	logic [5:0]      cnt_q;
	logic [DATA_W:0] rem_q;
	logic [DATA_W:0] den_q;
	logic [QW-1:0]   dvd_q;
	logic signed [DATA_W-1:0] quo_q;

	logic [DATA_W-1:0] mag;
	logic [DATA_W+1:0] trial;
	logic              qbit;
	logic [DATA_W+1:0] diff;
	logic [QW-1:0]     dvd_nx;

	always_comb begin
		mag    = req.num[DATA_W-1] ? DATA_W'(-req.num) : DATA_W'(req.num);
		trial  = {rem_q, dvd_q[QW-1]};
		diff   = trial - {1'b0, den_q};
		qbit   = (trial >= {1'b0, den_q});
		dvd_nx = {dvd_q[QW-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(QW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= {mag, {FRAC_W{1'b0}}};
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.num[DATA_W-1];
		end else if (busy_q) begin
			dvd_q <= dvd_nx;
			rem_q <= qbit ? diff[DATA_W:0] : trial[DATA_W:0];
			// saturate the final quotient on the last bit
			if (cnt_q == 6'(QW-1)) begin
				if (neg_q) begin
					if (dvd_nx > {{(QW-DATA_W-1){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}})
						quo_q <= 32'sh8000_0000;
					else
						quo_q <= -$signed(dvd_nx[DATA_W-1:0]);
				end else begin
					if (dvd_nx > {{(QW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}})
						quo_q <= 32'sh7FFF_FFFF;
					else
						quo_q <= $signed(dvd_nx[DATA_W-1:0]);
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// File: src/angle_gyro_kalman_filter.sv
// Top level: sequencer, state registers and configuration of the angle/gyro Kalman filter.
//
//  channel  dir   handshake       payload
//  sample   in    valid/ready     accel_angle, gyro_rate (Q8.24)
//  result   out   valid/ready     angle_estimate, rate_estimate, bias_estimate (Q8.24)
//  cfg      in    cfg_we          cfg_idx, cfg_data (Q8.24)
//
// Each sample takes ten passes through the shared multiplier, two gain divisions
// (start, 56 quotient bits, done) and one output step before the block returns to idle.
// With a nonpositive innovation variance the divisions are skipped.
// Reset (arst_n low) loads the default noise and step registers, zero angle and
// bias, and unit covariance diagonal. Ready is high only when idle. A result waits in
// the output register; the next sample is taken meanwhile and held at the end if the
// result is stalled.
module angle_gyro_kalman_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	akf_in_if.sink                        sample,
	akf_out_if.source                     result,
	input  logic                          cfg_we,
	input  logic [akf_pkg::CIDX_W-1:0]    cfg_idx,
	input  logic [akf_pkg::CFG_W-1:0]     cfg_data
);
	import akf_pkg::*;

	state_t state_q, state_nx;
	op_t    op_q, op_nx;

	logic [CFG_W-1:0] q_angle_q, q_gyro_q, r_meas_q, dt_q;
	logic signed [DATA_W-1:0] angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [DATA_W-1:0] accel_q, gyro_q, rate_q, err_q, t0_q, t1_q, k0_q, k1_q;
	logic signed [DATA_W:0]   den_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_angle_q, out_rate_q, out_bias_q;

	logic signed [DATA_W-1:0] mul_a, mul_b, mul_p, d_val;
	logic signed [DATA_W:0]   den_nx;
	div_req_t dreq;
	div_rsp_t drsp;
	logic     accept;

	assign accept = sample.valid && sample.ready;

	akf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
	akf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		d_val  = sat34($signed({2'b00, q_angle_q}) - {{2{ab_q[DATA_W-1]}}, ab_q}
			- {{2{ba_q[DATA_W-1]}}, ba_q});
		den_nx = $signed({2'b00, r_meas_q}) + {aa_q[DATA_W-1], aa_q};
		unique case (op_q)
			OP_ANG_P:  begin mul_a = rate_q;  mul_b = $signed({1'b0, dt_q}); end
			OP_AA_P:   begin mul_a = d_val;   mul_b = $signed({1'b0, dt_q}); end
			OP_AB_P:   begin mul_a = bb_q;    mul_b = $signed({1'b0, dt_q}); end
			OP_BB_P:   begin mul_a = $signed({1'b0, q_gyro_q}); mul_b = $signed({1'b0, dt_q}); end
			OP_AA_C:   begin mul_a = k0_q;    mul_b = t0_q;  end
			OP_AB_C:   begin mul_a = k0_q;    mul_b = t1_q;  end
			OP_BA_C:   begin mul_a = k1_q;    mul_b = t0_q;  end
			OP_BB_C:   begin mul_a = k1_q;    mul_b = t1_q;  end
			OP_ANG_C:  begin mul_a = k0_q;    mul_b = err_q; end
			OP_BIAS_C: begin mul_a = k1_q;    mul_b = err_q; end
			default:   begin mul_a = '0;      mul_b = '0;    end
		endcase
	end

	always_comb begin
		state_nx   = state_q;
		op_nx      = op_q;
		dreq.start = 1'b0;
		dreq.num   = (state_q == ST_DIV1) ? ba_q : aa_q;
		dreq.den   = den_q;
		unique case (state_q)
			ST_IDLE: if (accept) begin
				state_nx = ST_MUL;
				op_nx    = OP_ANG_P;
			end
			ST_MUL: state_nx = ST_WB;
			ST_WB: begin
				if (op_q == OP_BIAS_C) begin
					state_nx = ST_OUT;
				end else if (op_q == OP_BB_P && den_nx > 33'sd0) begin
					state_nx = ST_DIV0;
				end else begin
					state_nx = ST_MUL;
					op_nx    = op_t'(op_q + 4'd1);
				end
			end
			ST_DIV0: begin
				dreq.start = 1'b1;
				state_nx   = ST_DIV0W;
			end
			ST_DIV0W: if (drsp.done) state_nx = ST_DIV1;
			ST_DIV1: begin
				dreq.start = 1'b1;
				state_nx   = ST_DIV1W;
			end
			ST_DIV1W: if (drsp.done) begin
				state_nx = ST_MUL;
				op_nx    = OP_AA_C;
			end
			ST_OUT: if (!out_valid_q || result.ready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ANG_P;
			out_valid_q <= 1'b0;
			q_angle_q   <= Q_ANGLE_RST;
			q_gyro_q    <= Q_GYRO_RST;
			r_meas_q    <= R_MEAS_RST;
			dt_q        <= DT_RST;
			angle_q     <= '0;
			bias_q      <= '0;
			aa_q        <= ONE_Q24;
			ab_q        <= '0;
			ba_q        <= '0;
			bb_q        <= ONE_Q24;
		end else begin
			state_q <= state_nx;
			op_q    <= op_nx;
			if (cfg_we) begin
				if (cfg_idx == REG_Q_ANGLE) q_angle_q <= cfg_data;
				if (cfg_idx == REG_Q_GYRO)  q_gyro_q  <= cfg_data;
				if (cfg_idx == REG_R_MEAS)  r_meas_q  <= cfg_data;
				if (cfg_idx == REG_DT)      dt_q      <= cfg_data;
			end
			if (state_q == ST_OUT && (!out_valid_q || result.ready))
				out_valid_q <= 1'b1;
			else if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			if (state_q == ST_WB) begin
				unique case (op_q)
					OP_ANG_P, OP_ANG_C: angle_q <= sat34({{2{angle_q[DATA_W-1]}}, angle_q}
						+ {{2{mul_p[DATA_W-1]}}, mul_p});
					OP_AA_P: aa_q <= sat34({{2{aa_q[DATA_W-1]}}, aa_q} + {{2{mul_p[DATA_W-1]}}, mul_p});
					OP_AB_P: begin
						ab_q <= sat34({{2{ab_q[DATA_W-1]}}, ab_q} - {{2{mul_p[DATA_W-1]}}, mul_p});
						ba_q <= sat34({{2{ba_q[DATA_W-1]}}, ba_q} - {{2{mul_p[DATA_W-1]}}, mul_p});
					end
					OP_BB_P: bb_q <= sat34({{2{bb_q[DATA_W-1]}}, bb_q} + {{2{mul_p[DATA_W-1]}}, mul_p});
					OP_AA_C: aa_q <= sat34({{2{aa_q[DATA_W-1]}}, aa_q} - {{2{mul_p[DATA_W-1]}}, mul_p});
					OP_AB_C: ab_q <= sat34({{2{ab_q[DATA_W-1]}}, ab_q} - {{2{mul_p[DATA_W-1]}}, mul_p});
					OP_BA_C: ba_q <= sat34({{2{ba_q[DATA_W-1]}}, ba_q} - {{2{mul_p[DATA_W-1]}}, mul_p});
					OP_BB_C: bb_q <= sat34({{2{bb_q[DATA_W-1]}}, bb_q} - {{2{mul_p[DATA_W-1]}}, mul_p});
					OP_BIAS_C: bias_q <= sat34({{2{bias_q[DATA_W-1]}}, bias_q}
						+ {{2{mul_p[DATA_W-1]}}, mul_p});
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			accel_q <= sample.accel_angle;
			gyro_q  <= sample.gyro_rate;
			rate_q  <= sat34({{2{sample.gyro_rate[DATA_W-1]}}, sample.gyro_rate}
				- {{2{bias_q[DATA_W-1]}}, bias_q});
		end
		if (state_q == ST_WB && op_q == OP_BB_P) begin
			err_q <= sat34({{2{accel_q[DATA_W-1]}}, accel_q} - {{2{angle_q[DATA_W-1]}}, angle_q});
			den_q <= den_nx;
			t0_q  <= aa_q;
			t1_q  <= ab_q;
			// nonpositive innovation variance: zero gains
			k0_q  <= '0;
			k1_q  <= '0;
		end
		if (state_q == ST_DIV0W && drsp.done) k0_q <= drsp.quo;
		if (state_q == ST_DIV1W && drsp.done) k1_q <= drsp.quo;
		if (state_q == ST_OUT && (!out_valid_q || result.ready)) begin
			out_angle_q <= angle_q;
			out_bias_q  <= bias_q;
			out_rate_q  <= sat34({{2{gyro_q[DATA_W-1]}}, gyro_q} - {{2{bias_q[DATA_W-1]}}, bias_q});
		end
	end

	assign sample.ready          = (state_q == ST_IDLE);
	assign result.valid          = out_valid_q;
	assign result.angle_estimate = out_angle_q;
	assign result.rate_estimate  = out_rate_q;
	assign result.bias_estimate  = out_bias_q;

`ifndef SYNTH
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		!(dreq.start && drsp.busy)) else $error("divider started while busy");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample.ready) else $error("sample taken while busy");
	a_div_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == ST_DIV0W || state_q == ST_DIV1W))
		else $error("divider result with no consumer");
`endif

endmodule
